// ===== rtl/alpha_weighted_tap_accumulator_top_assert.svh =====
// Assertion macros used by the tap accumulator controller.
`ifndef ALPHA_WEIGHTED_TAP_ACCUMULATOR_TOP_ASSERT_SVH
`define ALPHA_WEIGHTED_TAP_ACCUMULATOR_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define AWTA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define AWTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/awta_pkg.sv =====
// Package: constants and controller/datapath interface types of the tap accumulator.
`default_nettype none

package awta_pkg;

  localparam int FRACTION_BITS = 14;
  localparam int MAX_TAPS      = 256;
  localparam int CHAN_MAX      = 255;

  localparam int CHAN_W  = 8;
  localparam int WGT_W   = 16;
  localparam int WA_W    = 24;   // alpha * weight
  localparam int PROD_W  = 32;   // colour * alpha * weight
  localparam int ASUM_W  = 40;
  localparam int CSUM_W  = 48;
  localparam int NUM_CH  = 3;
  localparam int QUO_W   = CHAN_W + 1;  // top bit flags quotient overflow
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W  = $clog2(DIV_STEPS);
  localparam int TAP_CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // register a beat and form alpha * weight
    logic acc;       // add the tap into the sums
    logic load;      // take sums apart for the divide, clear them
    logic div_step;  // one quotient bit per channel
    logic emit;      // write the result register
  } awta_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tap_final;  // current tap closes the output pixel
    logic out_busy;   // result register holds a beat that is stalled
  } awta_sts_t;

endpackage

`default_nettype wire

// ===== rtl/alpha_weighted_tap_accumulator_top.sv =====
// Top level: alpha-weighted filter tap accumulator with per-pixel divide.
// A tap that does not close a pixel is captured with alpha*weight, then accumulated.
// A closing tap is accumulated, its sums loaded, put through a 9-step restoring divide
// (three channels at once) and written as a result before the next beat is taken; a stalled older result delays it.
// The result waits in an output register while the output stalls.
// Asynchronous active-low reset clears the sums, tap count, controller and result valid.
`default_nettype none

module alpha_weighted_tap_accumulator_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [awta_pkg::CHAN_W-1:0]        pix_alpha_i,
  input  wire logic [awta_pkg::CHAN_W-1:0]        pix_red_i,
  input  wire logic [awta_pkg::CHAN_W-1:0]        pix_green_i,
  input  wire logic [awta_pkg::CHAN_W-1:0]        pix_blue_i,
  input  wire logic signed [awta_pkg::WGT_W-1:0]  tap_weight_i,
  input  wire logic                              last_tap_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [awta_pkg::CHAN_W-1:0]            out_alpha_o,
  output logic [awta_pkg::CHAN_W-1:0]            out_red_o,
  output logic [awta_pkg::CHAN_W-1:0]            out_green_o,
  output logic [awta_pkg::CHAN_W-1:0]            out_blue_o
);
  import awta_pkg::*;

  awta_cmd_t cmd;
  awta_sts_t sts;

  awta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  awta_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_alpha_i  (pix_alpha_i),
    .pix_red_i    (pix_red_i),
    .pix_green_i  (pix_green_i),
    .pix_blue_i   (pix_blue_i),
    .tap_weight_i (tap_weight_i),
    .last_tap_i   (last_tap_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_alpha_o  (out_alpha_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o)
  );

endmodule

`default_nettype wire

// ===== rtl/awta_ctrl.sv =====
// Controller: sequences capture, accumulate, divide and result write.
`default_nettype none

`include "alpha_weighted_tap_accumulator_top_assert.svh"

module awta_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire awta_pkg::awta_sts_t sts_i,
  output awta_pkg::awta_cmd_t      cmd_o
);
  import awta_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              in_accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = sts_i.tap_final ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        step_d  = STEP_W'(DIV_STEPS - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `AWTA_ASSERT_IMPL(a_acc_follows_beat, state_q == ST_ACC, $past(in_accept), "accumulate without an accepted beat")
  `AWTA_ASSERT_NEXT(a_load_starts_div, cmd_o.load, (state_q == ST_DIV) && (step_q == STEP_W'(DIV_STEPS - 1)), "divide not started after load")
  `AWTA_ASSERT_NEXT(a_div_ends, (state_q == ST_DIV) && (step_q == '0), state_q == ST_DONE, "divide did not end after its last step")
  `AWTA_ASSERT_IMPL(a_emit_when_free, cmd_o.emit, !sts_i.out_busy, "result written over a stalled beat")

endmodule

`default_nettype wire

// ===== rtl/awta_dp.sv =====
// Datapath: tap products, running sums, bit-serial divide and result register.
`default_nettype none

module awta_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [awta_pkg::CHAN_W-1:0] pix_alpha_i,
  input  wire logic [awta_pkg::CHAN_W-1:0] pix_red_i,
  input  wire logic [awta_pkg::CHAN_W-1:0] pix_green_i,
  input  wire logic [awta_pkg::CHAN_W-1:0] pix_blue_i,
  input  wire logic signed [awta_pkg::WGT_W-1:0] tap_weight_i,
  input  wire logic                       last_tap_i,
  input  wire awta_pkg::awta_cmd_t        cmd_i,
  output awta_pkg::awta_sts_t             sts_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [awta_pkg::CHAN_W-1:0]     out_alpha_o,
  output logic [awta_pkg::CHAN_W-1:0]     out_red_o,
  output logic [awta_pkg::CHAN_W-1:0]     out_green_o,
  output logic [awta_pkg::CHAN_W-1:0]     out_blue_o
);
  import awta_pkg::*;

  // Captured beat
  logic signed [WA_W-1:0]          wa_q;
  logic [NUM_CH-1:0][CHAN_W-1:0]   col_q;
  logic                            last_q;
  logic signed [WA_W-1:0]          wa_d;

  // Running sums and tap count
  logic [ASUM_W-1:0]               asum_q, asum_d;
  logic [NUM_CH-1:0][CSUM_W-1:0]   csum_q, csum_d;
  logic [TAP_CNT_W-1:0]            tap_cnt_q;

  // Divide state
  logic [CSUM_W-1:0]               dsh_q;
  logic [NUM_CH-1:0][CSUM_W-1:0]   rem_q, rem_d;
  logic [NUM_CH-1:0][QUO_W-1:0]    quo_q, quo_d;
  logic [NUM_CH-1:0]               neg_q;
  logic [CHAN_W-1:0]               ares_q;

  // Load-time values
  logic [ASUM_W-1:0]               den;
  logic [ASUM_W-1:0]               dmag;
  logic                            den_neg;
  logic signed [ASUM_W-1:0]        a_shr;
  logic [CHAN_W-1:0]               ares_d;
  logic [NUM_CH-1:0][CSUM_W-1:0]   nmag;
  logic [NUM_CH-1:0]               nneg;

  // Result register
  logic                            out_valid_q;
  logic [CHAN_W-1:0]               out_alpha_q;
  logic [NUM_CH-1:0][CHAN_W-1:0]   out_col_q;
  logic [NUM_CH-1:0][CHAN_W-1:0]   out_col_d;

  // alpha * weight, both operands at product width
  assign wa_d = $signed({{(WA_W-CHAN_W){1'b0}}, pix_alpha_i}) * WA_W'(tap_weight_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wa_q   <= wa_d;
      col_q  <= {pix_blue_i, pix_green_i, pix_red_i};
      last_q <= last_tap_i;
    end
  end

  // Tap accumulation: one colour product per lane
  always_comb begin
    logic signed [PROD_W-1:0] prod;
    asum_d = asum_q + ASUM_W'(wa_q);
    for (int c = 0; c < NUM_CH; c++) begin
      prod = $signed({{(PROD_W-CHAN_W){1'b0}}, col_q[c]}) * PROD_W'(wa_q);
      csum_d[c] = csum_q[c] + CSUM_W'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asum_q    <= '0;
      csum_q    <= '0;
      tap_cnt_q <= '0;
    end else if (cmd_i.acc) begin
      asum_q    <= asum_d;
      csum_q    <= csum_d;
      tap_cnt_q <= tap_cnt_q + 1'b1;
    end else if (cmd_i.load) begin
      asum_q    <= '0;
      csum_q    <= '0;
      tap_cnt_q <= '0;
    end
  end

  assign sts_o.tap_final = last_q || (tap_cnt_q == TAP_CNT_W'(MAX_TAPS - 1));
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  // Divisor, its magnitude and the alpha result
  always_comb begin
    den     = (asum_q == '0) ? ASUM_W'(1 << FRACTION_BITS) : asum_q;
    den_neg = den[ASUM_W-1];
    dmag    = den_neg ? (~den + 1'b1) : den;
    a_shr   = $signed(asum_q) >>> FRACTION_BITS;
    if (asum_q[ASUM_W-1]) begin
      ares_d = '0;
    end else if (|a_shr[ASUM_W-1:CHAN_W]) begin
      ares_d = CHAN_W'(CHAN_MAX);
    end else begin
      ares_d = a_shr[CHAN_W-1:0];
    end
    for (int c = 0; c < NUM_CH; c++) begin
      nneg[c] = csum_q[c][CSUM_W-1];
      nmag[c] = nneg[c] ? (~csum_q[c] + 1'b1) : csum_q[c];
    end
  end

  // Restoring divide step; first step tests for a quotient above the byte range
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (rem_q[c] >= dsh_q) begin
        rem_d[c] = rem_q[c] - dsh_q;
        quo_d[c] = {quo_q[c][QUO_W-2:0], 1'b1};
      end else begin
        rem_d[c] = rem_q[c];
        quo_d[c] = {quo_q[c][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dsh_q  <= CSUM_W'(dmag) << CHAN_W;
      rem_q  <= nmag;
      quo_q  <= '0;
      neg_q  <= nneg ^ {NUM_CH{den_neg}};
      ares_q <= ares_d;
    end else if (cmd_i.div_step) begin
      dsh_q <= dsh_q >> 1;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Clamp quotients into a byte
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (neg_q[c]) begin
        out_col_d[c] = '0;
      end else if (quo_q[c][QUO_W-1]) begin
        out_col_d[c] = CHAN_W'(CHAN_MAX);
      end else begin
        out_col_d[c] = quo_q[c][CHAN_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_alpha_q <= ares_q;
      out_col_q   <= out_col_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_alpha_o = out_alpha_q;
  assign out_red_o   = out_col_q[0];
  assign out_green_o = out_col_q[1];
  assign out_blue_o  = out_col_q[2];

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the alpha-weighted tap accumulator: taps in, checked ARGB pixels out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import awta_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [CHAN_W-1:0]       alpha;
    logic [CHAN_W-1:0]       red;
    logic [CHAN_W-1:0]       green;
    logic [CHAN_W-1:0]       blue;
    logic signed [WGT_W-1:0] weight;
    logic                    last;
  } tap_t;

  typedef struct {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // DUT ports
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [CHAN_W-1:0]       pix_alpha_i  = '0;
  logic [CHAN_W-1:0]       pix_red_i    = '0;
  logic [CHAN_W-1:0]       pix_green_i  = '0;
  logic [CHAN_W-1:0]       pix_blue_i   = '0;
  logic signed [WGT_W-1:0] tap_weight_i = '0;
  logic                    last_tap_i   = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic [CHAN_W-1:0]       out_alpha_o;
  logic [CHAN_W-1:0]       out_red_o;
  logic [CHAN_W-1:0]       out_green_o;
  logic [CHAN_W-1:0]       out_blue_o;

  // Pixel accumulator state of the predictor
  longint acc_alpha;
  longint acc_red;
  longint acc_green;
  longint acc_blue;
  int     taps_in_pixel;
  pixel_t expected_px[$];

  int taps_sent      = 0;
  int pixels_checked = 0;
  int fail_count     = 0;
  int src_idle_pct   = 18;
  int sink_stall_pct = 18;
  int cycle_count    = 0;

  alpha_weighted_tap_accumulator_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels outstanding", cycle_count,
               expected_px.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result-side stall, changed at the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= (sink_stall_pct != 0) && ($urandom_range(0, 99) < sink_stall_pct);
  end

  function automatic logic [CHAN_W-1:0] sat_byte(longint v);
    if (v < 0) return '0;
    if (v > CHAN_MAX) return CHAN_W'(CHAN_MAX);
    return v[CHAN_W-1:0];
  endfunction

  // Accumulate one tap; on a closing tap queue the expected pixel and clear
  function automatic void predict_tap(tap_t t);
    longint wa;
    longint divisor;
    pixel_t px;
    wa = longint'(t.alpha) * longint'(t.weight);
    acc_alpha += wa;
    acc_red   += longint'(t.red) * wa;
    acc_green += longint'(t.green) * wa;
    acc_blue  += longint'(t.blue) * wa;
    taps_in_pixel++;
    if (!t.last && taps_in_pixel < MAX_TAPS) return;
    px.alpha = (acc_alpha < 0) ? '0 : sat_byte(acc_alpha >>> FRACTION_BITS);
    // zero alpha sum divides by one in fixed point
    divisor  = (acc_alpha == 0) ? (longint'(1) <<< FRACTION_BITS) : acc_alpha;
    px.red   = sat_byte(acc_red / divisor);
    px.green = sat_byte(acc_green / divisor);
    px.blue  = sat_byte(acc_blue / divisor);
    expected_px.push_back(px);
    acc_alpha     = 0;
    acc_red       = 0;
    acc_green     = 0;
    acc_blue      = 0;
    taps_in_pixel = 0;
  endfunction

  function automatic tap_t make_tap(int a, int r, int g, int b, int w, bit l);
    tap_t t;
    t.alpha  = a[CHAN_W-1:0];
    t.red    = r[CHAN_W-1:0];
    t.green  = g[CHAN_W-1:0];
    t.blue   = b[CHAN_W-1:0];
    t.weight = w[WGT_W-1:0];
    t.last   = l;
    return t;
  endfunction

  function automatic tap_t random_tap();
    tap_t t;
    t.alpha  = CHAN_W'($urandom_range(0, CHAN_MAX));
    t.red    = CHAN_W'($urandom_range(0, CHAN_MAX));
    t.green  = CHAN_W'($urandom_range(0, CHAN_MAX));
    t.blue   = CHAN_W'($urandom_range(0, CHAN_MAX));
    t.weight = WGT_W'($urandom);
    t.last   = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Send one tap beat, with random idle cycles ahead of it
  task automatic send_tap(tap_t t);
    @(negedge clk_i);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pix_alpha_i  <= t.alpha;
    pix_red_i    <= t.red;
    pix_green_i  <= t.green;
    pix_blue_i   <= t.blue;
    tap_weight_i <= t.weight;
    last_tap_i   <= t.last;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_tap(t);
    taps_sent++;
  endtask

  // Check each accepted result beat against the oldest expected pixel
  always @(posedge clk_i) begin : check_results
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_px.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("Unexpected pixel a=%0d r=%0d g=%0d b=%0d", out_alpha_o, out_red_o,
                   out_green_o, out_blue_o);
      end else begin
        want = expected_px.pop_front();
        if (out_alpha_o !== want.alpha || out_red_o !== want.red ||
            out_green_o !== want.green || out_blue_o !== want.blue) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("Pixel %0d mismatch: expected a=%0d r=%0d g=%0d b=%0d, got a=%0d r=%0d g=%0d b=%0d",
                     pixels_checked, want.alpha, want.red, want.green, want.blue,
                     out_alpha_o, out_red_o, out_green_o, out_blue_o);
        end
        pixels_checked++;
      end
    end
  end

  // One pixel of random taps: mostly kernel-like, some noise
  task automatic send_random_pixel();
    int   n;
    int   kind;
    int   w;
    tap_t t;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // noise: fully random taps, the pixel may close anywhere or stay open
      n = $urandom_range(1, 4);
      repeat (n) send_tap(random_tap());
      return;
    end
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      t = random_tap();
      if ($urandom_range(0, 9) < 7) t.alpha = CHAN_W'(CHAN_MAX);
      else if ($urandom_range(0, 19) == 0) t.alpha = '0;
      if (kind < 80) begin
        // filter-like weights: mostly positive, some negative lobes
        w = $urandom_range(0, 1 << FRACTION_BITS);
        if ($urandom_range(0, 4) == 0) w = -int'($urandom_range(0, 1 << (FRACTION_BITS - 2)));
        t.weight = WGT_W'(w);
      end
      t.last = (i == n - 1);
      send_tap(t);
    end
  endtask

  task automatic test_single_tap_extremes();
    send_tap(make_tap(255, 0, 128, 255, 1 << FRACTION_BITS, 1));  // unity weight
    send_tap(make_tap(255, 255, 255, 255, 32767, 1));              // alpha clamps high
    send_tap(make_tap(255, 10, 20, 30, -32768, 1));                // negative alpha sum
    send_tap(make_tap(128, 1, 2, 3, 0, 1));                        // zero weight
    send_tap(make_tap(1, 255, 0, 255, 1, 1));                      // tiny alpha sum
    send_tap(make_tap(0, 0, 0, 0, 0, 1));
    send_tap(make_tap(255, 255, 255, 255, -1, 1));
  endtask

  task automatic test_zero_alpha_sum();
    send_tap(make_tap(0, 255, 255, 255, 12345, 1));                 // alpha zero
    // cancelling weights: colors divided by one in fixed point
    send_tap(make_tap(255, 255, 0, 1, 1 << FRACTION_BITS, 0));
    send_tap(make_tap(255, 0, 255, 0, -(1 << FRACTION_BITS), 1));
  endtask

  task automatic test_negative_and_overflow();
    // negative color quotient with positive alpha sum
    send_tap(make_tap(255, 0, 0, 0, 1 << FRACTION_BITS, 0));
    send_tap(make_tap(1, 255, 255, 255, -(1 << FRACTION_BITS), 1));
    // quotient far above 255
    send_tap(make_tap(255, 255, 255, 255, 32767, 0));
    send_tap(make_tap(254, 0, 0, 0, -32768, 1));
    // slightly negative alpha sum over large color sums
    send_tap(make_tap(255, 255, 255, 255, 32767, 0));
    send_tap(make_tap(255, 0, 0, 0, -32768, 1));
    // ordinary four-tap pixel
    send_tap(make_tap(255, 40, 90, 200, 2000, 0));
    send_tap(make_tap(200, 60, 80, 100, 7000, 0));
    send_tap(make_tap(255, 70, 30, 220, 7000, 0));
    send_tap(make_tap(128, 80, 10, 250, 384, 1));
  endtask

  // Taps past the limit close a pixel without last_tap
  task automatic test_tap_limit();
    for (int i = 0; i < MAX_TAPS + 10; i++) send_tap(random_tap_no_last());
    send_tap(make_tap(255, 1, 2, 3, 1 << FRACTION_BITS, 1));
  endtask

  function automatic tap_t random_tap_no_last();
    tap_t t;
    t = random_tap();
    t.last = 1'b0;
    return t;
  endfunction

  task automatic test_random_pixels(int n_taps);
    int first;
    first = taps_sent;
    while (taps_sent - first < n_taps) send_random_pixel();
  endtask

  task automatic test_back_to_back(int n_taps);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_pixels(n_taps);
    src_idle_pct   = 18;
    sink_stall_pct = 18;
  endtask

  initial begin
    acc_alpha     = 0;
    acc_red       = 0;
    acc_green     = 0;
    acc_blue      = 0;
    taps_in_pixel = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_tap_extremes();
    test_zero_alpha_sum();
    test_negative_and_overflow();
    test_tap_limit();
    test_random_pixels(300);
    test_back_to_back(120);
    test_random_pixels(100);

    // close any pixel left open by noise taps
    if (taps_in_pixel != 0) send_tap(make_tap(255, 9, 99, 199, 1 << FRACTION_BITS, 1));
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d taps, checked %0d pixels, including the tap limit,", taps_sent,
             pixels_checked);
    $display("zero and negative sums, clamping, and random idle and stall.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
